@@ rtl/core/cwsplit_pkg.sv @@
package cwsplit_pkg;

   // default geometry of the line store
   localparam int WORDS_PER_LINE_DEF = 4;
   localparam int CHARS_PER_WORD_DEF = 8;

   // queue depths between the parts
   localparam int OP_QUEUE_DEPTH  = 4;
   localparam int RSP_QUEUE_DEPTH = 2;

   // received byte codes
   localparam logic [7:0] BYTE_NUL       = 8'd0;
   localparam logic [7:0] BYTE_BACKSPACE = 8'd8;
   localparam logic [7:0] BYTE_NEWLINE   = 8'd10;
   localparam logic [7:0] BYTE_RETURN    = 8'd13;
   localparam logic [7:0] BYTE_SPACE     = 8'd32;

   // classified operations
   localparam logic [1:0] OP_CHAR      = 2'd0;
   localparam logic [1:0] OP_SPACE     = 2'd1;
   localparam logic [1:0] OP_BACKSPACE = 2'd2;
   localparam logic [1:0] OP_NEWLINE   = 2'd3;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] rx_byte;
   } op_type;

   typedef struct packed {
      logic [1:0]  word_number;
      logic [63:0] word_chars;
      logic [3:0]  word_length;
      logic        dropped_chars;
      logic        last_word;
   } rsp_type;

endpackage

@@ rtl/core/command_line_word_splitter.sv @@
// command line word splitter: received bytes go in one per cycle and are split
// into up to WORDS_PER_LINE space-separated words of up to CHARS_PER_WORD
// characters; backspace edits the current word, carriage return and nul are
// ignored, and newline sends out one word per slot (slot 0 first, last_word on
// the final slot) and clears the line. characters that find no room are dropped
// and dropped_chars is set on every word of that line. a byte is taken every
// cycle while req_full is low; a front part classifies it into a four-entry
// queue and a back part applies it to the word store. a newline holds the
// back part until it has sent all WORDS_PER_LINE words, one word per cycle,
// limited by how fast words are popped; bytes keep queuing behind it until
// the queue fills. words wait in a two-entry queue so the back part runs on
// while the oldest word is still on the rsp_ ports.
module command_line_word_splitter #(
   parameter int WORDS_PER_LINE = cwsplit_pkg::WORDS_PER_LINE_DEF,
   parameter int CHARS_PER_WORD = cwsplit_pkg::CHARS_PER_WORD_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // received bytes
   input  logic        req_push,
   input  logic [7:0]  req_rx_byte,
   output logic        req_full,
   // finished words
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [1:0]  rsp_word_number,
   output logic [63:0] rsp_word_chars,
   output logic [3:0]  rsp_word_length,
   output logic        rsp_dropped_chars,
   output logic        rsp_last_word
);

   import cwsplit_pkg::*;

   op_type  op_head;
   logic    op_empty;
   logic    op_pop;
   rsp_type rsp_item;
   rsp_type rsp_head;
   logic    rsp_push;
   logic    rsp_full;

   // front: classify bytes, drop return and nul, queue the rest
   cwsplit_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_rx_byte (req_rx_byte),
      .req_full    (req_full),
      .op_pop      (op_pop),
      .op_head     (op_head),
      .op_empty    (op_empty)
   );

   // back: word store, lengths, current slot and drop flag
   cwsplit_back #(
      .WORDS_PER_LINE (WORDS_PER_LINE),
      .CHARS_PER_WORD (CHARS_PER_WORD)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .op_head  (op_head),
      .op_empty (op_empty),
      .op_pop   (op_pop),
      .rsp_push (rsp_push),
      .rsp_item (rsp_item),
      .rsp_full (rsp_full)
   );

   // output queue of finished words
   cwsplit_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RSP_QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_item),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_head),
      .empty     (rsp_empty)
   );

   assign rsp_word_number   = rsp_head.word_number;
   assign rsp_word_chars    = rsp_head.word_chars;
   assign rsp_word_length   = rsp_head.word_length;
   assign rsp_dropped_chars = rsp_head.dropped_chars;
   assign rsp_last_word     = rsp_head.last_word;

endmodule

@@ rtl/core/cwsplit_fifo.sv @@
module cwsplit_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/core/cwsplit_front.sv @@
module cwsplit_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   input  logic [7:0]           req_rx_byte,
   output logic                 req_full,
   input  logic                 op_pop,
   output cwsplit_pkg::op_type  op_head,
   output logic                 op_empty
);

   import cwsplit_pkg::*;

   op_type item;
   logic   keep;

   // return and nul never reach the back part
   always_comb begin
      item.rx_byte = req_rx_byte;
      keep         = 1'b1;
      case (req_rx_byte)
         BYTE_NEWLINE:   item.op = OP_NEWLINE;
         BYTE_SPACE:     item.op = OP_SPACE;
         BYTE_BACKSPACE: item.op = OP_BACKSPACE;
         BYTE_RETURN, BYTE_NUL: begin
            item.op = OP_CHAR;
            keep    = 1'b0;
         end
         default:        item.op = OP_CHAR;
      endcase
   end

   cwsplit_fifo #(
      .WIDTH ($bits(op_type)),
      .DEPTH (OP_QUEUE_DEPTH)
   ) u_op_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push & keep),
      .push_data (item),
      .full      (req_full),
      .pop       (op_pop),
      .pop_data  (op_head),
      .empty     (op_empty)
   );

endmodule

@@ rtl/core/cwsplit_back.sv @@
module cwsplit_back #(
   parameter int WORDS_PER_LINE = cwsplit_pkg::WORDS_PER_LINE_DEF,
   parameter int CHARS_PER_WORD = cwsplit_pkg::CHARS_PER_WORD_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cwsplit_pkg::op_type  op_head,
   input  logic                 op_empty,
   output logic                 op_pop,
   output logic                 rsp_push,
   output cwsplit_pkg::rsp_type rsp_item,
   input  logic                 rsp_full
);

   import cwsplit_pkg::*;

   localparam int WIDX_W = (WORDS_PER_LINE > 1) ? $clog2(WORDS_PER_LINE) : 1;
   localparam int CUR_W  = $clog2(WORDS_PER_LINE + 1);
   localparam int LEN_W  = $clog2(CHARS_PER_WORD + 1);
   localparam int POS_W  = (CHARS_PER_WORD > 1) ? $clog2(CHARS_PER_WORD) : 1;
   localparam logic [WIDX_W-1:0] LAST_IDX = WIDX_W'(WORDS_PER_LINE - 1);

   // character store: bytes past a word's length are masked on the way out
   logic [7:0]        store_ff [WORDS_PER_LINE][CHARS_PER_WORD];
   logic [LEN_W-1:0]  lens_ff  [WORDS_PER_LINE];
   logic [LEN_W-1:0]  lens_in  [WORDS_PER_LINE];
   logic [CUR_W-1:0]  cur_ff, cur_in;
   logic              ovf_ff, ovf_in;
   logic [WIDX_W-1:0] emit_idx_ff, emit_idx_in;

   logic              cur_valid;
   logic [WIDX_W-1:0] cur_idx;
   logic [LEN_W-1:0]  cur_len;
   logic              store_we;
   logic [LEN_W-1:0]  emit_len;
   logic [63:0]       emit_chars;
   logic              is_newline;

   assign cur_valid  = (cur_ff < CUR_W'(WORDS_PER_LINE));
   assign cur_idx    = cur_ff[WIDX_W-1:0];
   assign cur_len    = cur_valid ? lens_ff[cur_idx] : '0;
   assign is_newline = ~op_empty & (op_head.op == OP_NEWLINE);
   assign emit_len   = lens_ff[emit_idx_ff];

   always_comb begin
      emit_chars = '0;
      for (int c = 0; c < CHARS_PER_WORD; c++) begin
         if (LEN_W'(c) < emit_len) begin
            emit_chars[8*c +: 8] = store_ff[emit_idx_ff][c];
         end
      end
   end

   assign rsp_push                = is_newline & ~rsp_full;
   assign rsp_item.word_number    = 2'(emit_idx_ff);
   assign rsp_item.word_chars     = emit_chars;
   assign rsp_item.word_length    = 4'(emit_len);
   assign rsp_item.dropped_chars  = ovf_ff;
   assign rsp_item.last_word      = (emit_idx_ff == LAST_IDX);

   always_comb begin
      lens_in     = lens_ff;
      cur_in      = cur_ff;
      ovf_in      = ovf_ff;
      emit_idx_in = emit_idx_ff;
      op_pop      = 1'b0;
      store_we    = 1'b0;
      if (!op_empty) begin
         case (op_head.op)
            OP_NEWLINE: begin
               // one word slot per cycle while rsp_full is low, newline leaves after the last slot
               if (!rsp_full) begin
                  if (emit_idx_ff == LAST_IDX) begin
                     op_pop      = 1'b1;
                     emit_idx_in = '0;
                     cur_in      = '0;
                     ovf_in      = 1'b0;
                     for (int i = 0; i < WORDS_PER_LINE; i++) begin
                        lens_in[i] = '0;
                     end
                  end else begin
                     emit_idx_in = emit_idx_ff + 1'b1;
                  end
               end
            end
            OP_SPACE: begin
               op_pop = 1'b1;
               if (cur_valid) begin
                  if (cur_len != '0) begin
                     cur_in = cur_ff + 1'b1;
                  end
               end else begin
                  cur_in = '0;
                  for (int i = 0; i < WORDS_PER_LINE; i++) begin
                     lens_in[i] = '0;
                  end
               end
            end
            OP_BACKSPACE: begin
               op_pop = 1'b1;
               if (cur_len != '0) begin
                  lens_in[cur_idx] = cur_len - 1'b1;
               end else if (cur_ff != '0) begin
                  cur_in = cur_ff - 1'b1;
               end
            end
            default: begin
               op_pop = 1'b1;
               if (cur_valid && (cur_len < LEN_W'(CHARS_PER_WORD))) begin
                  store_we         = 1'b1;
                  lens_in[cur_idx] = cur_len + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff      <= '0;
         ovf_ff      <= 1'b0;
         emit_idx_ff <= '0;
         for (int i = 0; i < WORDS_PER_LINE; i++) begin
            lens_ff[i] <= '0;
         end
      end else begin
         cur_ff      <= cur_in;
         ovf_ff      <= ovf_in;
         emit_idx_ff <= emit_idx_in;
         lens_ff     <= lens_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_ff[cur_idx][cur_len[POS_W-1:0]] <= op_head.rx_byte;
      end
   end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps

// scoreboard: keeps its own copy of the line being typed and the words that
// each newline must send out, oldest first
class word_scoreboard;
   localparam int NWORDS = cwsplit_pkg::WORDS_PER_LINE_DEF;
   localparam int NCHARS = cwsplit_pkg::CHARS_PER_WORD_DEF;

   logic [7:0]          line_chars [NWORDS][NCHARS];
   int unsigned         char_count [NWORDS];
   int unsigned         cur_word;
   bit                  chars_dropped;
   cwsplit_pkg::rsp_type pending_words [$];
   int                  errors;

   function new();
      clear_line();
      cur_word = 0;
      chars_dropped = 0;
      errors = 0;
   endfunction

   function void clear_line();
      for (int i = 0; i < NWORDS; i++) begin
         char_count[i] = 0;
         for (int c = 0; c < NCHARS; c++) line_chars[i][c] = 8'd0;
      end
   endfunction

   function void report_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
   endfunction

   // applies one received byte to the line and queues any words it sends
   function void split_byte(logic [7:0] b);
      cwsplit_pkg::rsp_type w;
      if (b == cwsplit_pkg::BYTE_NEWLINE) begin
         for (int i = 0; i < NWORDS; i++) begin
            w.word_number   = 2'(i);
            w.word_chars    = 64'd0;
            for (int c = 0; c < int'(char_count[i]); c++)
               w.word_chars[8*c +: 8] = line_chars[i][c];
            w.word_length   = 4'(char_count[i]);
            w.dropped_chars = chars_dropped;
            w.last_word     = (i == NWORDS - 1);
            pending_words.push_back(w);
         end
         clear_line();
         cur_word = 0;
         chars_dropped = 0;
      end else if (b == cwsplit_pkg::BYTE_RETURN || b == cwsplit_pkg::BYTE_NUL) begin
         // ignored
      end else if (b == cwsplit_pkg::BYTE_SPACE) begin
         if (cur_word < NWORDS) begin
            if (char_count[cur_word] != 0) cur_word++;
         end else begin
            clear_line();
            cur_word = 0;
         end
      end else if (b == cwsplit_pkg::BYTE_BACKSPACE) begin
         if (cur_word < NWORDS && char_count[cur_word] != 0) begin
            char_count[cur_word]--;
            line_chars[cur_word][char_count[cur_word]] = 8'd0;
         end else if (cur_word > 0) begin
            cur_word--;
         end
      end else if (cur_word < NWORDS && char_count[cur_word] < NCHARS) begin
         line_chars[cur_word][char_count[cur_word]] = b;
         char_count[cur_word]++;
      end else begin
         chars_dropped = 1;
      end
   endfunction

   function void note_byte(logic [7:0] b);
      split_byte(b);
   endfunction

   function void check_word(cwsplit_pkg::rsp_type got);
      cwsplit_pkg::rsp_type exp;
      if (pending_words.size() == 0) begin
         report_mismatch($sformatf("word %0d arrived with none expected", got.word_number));
         return;
      end
      exp = pending_words.pop_front();
      if (got.word_number !== exp.word_number)
         report_mismatch($sformatf("word_number %0d, expected %0d",
                                   got.word_number, exp.word_number));
      if (got.word_chars !== exp.word_chars)
         report_mismatch($sformatf("word %0d chars %h, expected %h",
                                   exp.word_number, got.word_chars, exp.word_chars));
      if (got.word_length !== exp.word_length)
         report_mismatch($sformatf("word %0d length %0d, expected %0d",
                                   exp.word_number, got.word_length, exp.word_length));
      if (got.dropped_chars !== exp.dropped_chars)
         report_mismatch($sformatf("word %0d dropped_chars %b, expected %b",
                                   exp.word_number, got.dropped_chars, exp.dropped_chars));
      if (got.last_word !== exp.last_word)
         report_mismatch($sformatf("word %0d last_word %b, expected %b",
                                   exp.word_number, got.last_word, exp.last_word));
   endfunction
endclass

module tb;
   import cwsplit_pkg::*;

   localparam int RANDOM_BYTES   = 400;
   localparam int CALM_FROM      = 330;  // no idling on either side after this
   localparam int HOLD_AT        = 150;  // where the long result stall starts
   localparam int HOLD_CYCLES    = 80;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES    = 20;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic [7:0]  req_rx_byte = 8'd0;
   logic        req_full;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [1:0]  rsp_word_number;
   logic [63:0] rsp_word_chars;
   logic [3:0]  rsp_word_length;
   logic        rsp_dropped_chars;
   logic        rsp_last_word;

   word_scoreboard sb = new();
   rsp_type        seen_word;
   int             sent_count = 0;
   int             idle_cycles = 0;
   bit             calm = 0;       // last part of the run: no idling
   bit             hold_rsp = 0;   // asks the receiver for one long stall
   bit             hold_done = 0;  // the long stall has been run

   command_line_word_splitter dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_rx_byte      (req_rx_byte),
      .req_full         (req_full),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_word_number  (rsp_word_number),
      .rsp_word_chars   (rsp_word_chars),
      .rsp_word_length  (rsp_word_length),
      .rsp_dropped_chars(rsp_dropped_chars),
      .rsp_last_word    (rsp_last_word)
   );

   always #5 clock = ~clock;

   // monitor: results are checked before the byte of the same edge is noted,
   // a newline never sends a word on the edge that takes it
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_pop && !rsp_empty) begin
            seen_word.word_number   = rsp_word_number;
            seen_word.word_chars    = rsp_word_chars;
            seen_word.word_length   = rsp_word_length;
            seen_word.dropped_chars = rsp_dropped_chars;
            seen_word.last_word     = rsp_last_word;
            sb.check_word(seen_word);
         end
         if (req_push && !req_full) sb.note_byte(req_rx_byte);
      end
   end

   // watchdog: cycles in a row with no word moving on either side
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // receiver: random stall bursts, one long hold on request, none when calm
   initial begin
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp) begin
            hold_rsp = 0;
            rsp_pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_pop <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end else begin
            rsp_pop <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // drive one input byte and hold it until the block takes it
   task automatic send_byte(input logic [7:0] b);
      req_push    <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_full);
      if (b != BYTE_RETURN && b != BYTE_NUL) sent_count++;
   endtask

   task automatic idle_sender(input int cycles);
      req_push <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // same as send_byte but sometimes after a short gap
   task automatic offer(input logic [7:0] b);
      if (!calm && $urandom_range(0, 7) == 0) idle_sender($urandom_range(1, 5));
      send_byte(b);
   endtask

   // sender stops and waits until every queued word has come out; the first
   // edge lets the monitor note the last byte taken
   task automatic wait_drained();
      req_push <= 1'b0;
      @(posedge clock);
      while (sb.pending_words.size() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] random_char();
      logic [7:0] b;
      do b = 8'($urandom_range(1, 255));
      while (b == BYTE_BACKSPACE || b == BYTE_NEWLINE || b == BYTE_RETURN ||
             b == BYTE_SPACE);
      return b;
   endfunction

   // a well-formed line with random words, a few edits and the odd overlong
   // word or extra word so the drop paths get hit too
   task automatic send_line();
      int n_words;
      int n_chars;
      n_words = $urandom_range(0, 5);
      for (int k = 0; k < n_words; k++) begin
         n_chars = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 11)
                                                : $urandom_range(1, 8);
         for (int j = 0; j < n_chars; j++) begin
            offer(random_char());
            if ($urandom_range(0, 15) == 0) offer(BYTE_BACKSPACE);
            if ($urandom_range(0, 31) == 0) offer(BYTE_RETURN);
         end
         repeat ($urandom_range(1, 2)) offer(BYTE_SPACE);
         if ($urandom_range(0, 11) == 0) offer(BYTE_BACKSPACE);
      end
      if ($urandom_range(0, 3) == 0) offer(BYTE_RETURN);
      offer(BYTE_NEWLINE);
   endtask

   // main sender
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty line, backspace on empty word 0, ignored bytes
      offer(BYTE_NEWLINE);
      offer(BYTE_BACKSPACE);
      offer(BYTE_NUL);
      offer(BYTE_RETURN);
      // word 0 filled with extremes, the ninth character is dropped
      offer(8'hff); offer(8'h01); offer(8'h02); offer(8'h03);
      offer(8'h04); offer(8'h05); offer(8'h06); offer(8'h07);
      offer(8'h80);
      offer(BYTE_BACKSPACE);
      // double space does not open an empty word
      offer(BYTE_SPACE); offer(BYTE_SPACE);
      offer(8'h7f); offer(BYTE_SPACE);
      offer(8'h41); offer(BYTE_SPACE);
      offer(8'h42); offer(BYTE_SPACE);
      // no free slot: character dropped, backspace steps back to the last slot
      offer(8'h43);
      offer(BYTE_BACKSPACE);
      // space with no slot left clears the line but keeps the drop flag
      offer(BYTE_SPACE); offer(BYTE_SPACE);
      offer(BYTE_NEWLINE);
      wait_drained();

      // random part: mostly whole lines, some raw noise
      sent_count = 0;
      while (sent_count < RANDOM_BYTES) begin
         if (sent_count >= CALM_FROM) calm = 1;
         if (sent_count >= HOLD_AT && !hold_done) begin
            // long result stall: push six short lines so that input backs up
            hold_done = 1;
            wait_drained();
            hold_rsp = 1;
            repeat (6) begin
               send_byte(random_char());
               send_byte(BYTE_NEWLINE);
            end
            wait_drained();
         end else if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 6)) offer(8'($urandom_range(0, 255)));
         end else begin
            send_line();
         end
      end
      offer(BYTE_NEWLINE);
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (sb.errors == 0 && sb.pending_words.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
